FILE: sv/ard_pkg.sv
// Shared types and constants for the ARM relocation addend decoder.
// Relocation type codes, status codes, field widths and the decode result struct.
`timescale 1ns / 1ps

package ard_pkg;

    localparam int TYPE_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int WORD_W   = 32;
    localparam int SIDX_W   = 16;
    localparam int SCNT_W   = 17;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 80;

    // ELF ARM relocation type numbers
    localparam logic [TYPE_W-1:0] T_NONE       = 8'd0;
    localparam logic [TYPE_W-1:0] T_ABS32      = 8'd2;
    localparam logic [TYPE_W-1:0] T_REL32      = 8'd3;
    localparam logic [TYPE_W-1:0] T_THM_CALL   = 8'd10;
    localparam logic [TYPE_W-1:0] T_CALL       = 8'd28;
    localparam logic [TYPE_W-1:0] T_JUMP24     = 8'd29;
    localparam logic [TYPE_W-1:0] T_THM_JUMP24 = 8'd30;
    localparam logic [TYPE_W-1:0] T_TARGET1    = 8'd38;
    localparam logic [TYPE_W-1:0] T_V4BX       = 8'd40;
    localparam logic [TYPE_W-1:0] T_TARGET2    = 8'd41;
    localparam logic [TYPE_W-1:0] T_PREL31     = 8'd42;
    localparam logic [TYPE_W-1:0] T_MOVW       = 8'd43;
    localparam logic [TYPE_W-1:0] T_MOVT       = 8'd44;
    localparam logic [TYPE_W-1:0] T_THM_MOVW   = 8'd47;
    localparam logic [TYPE_W-1:0] T_THM_MOVT   = 8'd48;
    localparam logic [TYPE_W-1:0] T_THM_PC11   = 8'd102;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd2;

    localparam logic [WORD_W-1:0] MASK_MOVT     = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] MASK_MOVW     = 32'h0000_FFFF;
    localparam logic [WORD_W-1:0] MASK_THM_CALL = 32'hFFFF_FFFE;
    localparam logic [WORD_W-1:0] MASK_FULL     = 32'hFFFF_FFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED = 3'd0,
        ST_IGNORED = 3'd1,
        ST_OUTSIDE = 3'd2,
        ST_INVALID = 3'd3,
        ST_BADSYM  = 3'd4
    } status_t;

    // decode stage result, handed to the addend stage
    typedef struct packed {
        status_t             status;
        logic [TYPE_W-1:0]   final_type;
        logic [WORD_W-1:0]   target;
        logic [WORD_W-1:0]   sym_masked;
    } dec_t;

endpackage

FILE: sv/arm_relocation_addend_decoder.sv
// ARM ELF REL relocation addend decoder, top level.
// Pipeline: an input transfer passes the input, decode and result registers to m_tdata.
// Throughput: one entry per cycle while m_tready does not stall the pipe; the decode stage
//   (type decode and one 32-bit add) and the addend stage (one 32-bit subtract and range check) set it.
// Reset: aresetn synchronous active low; clears stage valids and config registers.
// Depends on ard_pkg and ard_decode.
`timescale 1ns / 1ps

module arm_relocation_addend_decoder
    import ard_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_wdata,
    // input entries
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, low bit up: reloc_type[7:0], place_address[39:8], insn_word[71:40],
    //   symbol_index[87:72], symbol_value[119:88]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, low bit up: status[2:0], final_type[10:3], target_value[42:11],
    //   addend_value[74:43], short_addend[75], zero pad[79:76]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // configuration registers
    logic [ADDR_W-1:0] text_base_reg;
    logic [ADDR_W-1:0] text_size_reg;
    logic [SCNT_W-1:0] symbol_count_reg;

    // pipeline: input register -> decode register -> result register
    logic                  in_valid_reg;
    logic [S_TDATA_W-1:0]  in_data_reg;
    logic                  dec_valid_reg;
    dec_t                  dec_reg;
    dec_t                  dec_next;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [M_TDATA_W-1:0]  out_data_next;
    logic [WORD_W-1:0]     addend;
    logic                  short_addend;
    logic                  advance;

    // Whole pipe moves together whenever the result slot is free or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Config writes; an unused index is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_base_reg    <= '0;
            text_size_reg    <= '0;
            symbol_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TEXT_BASE:    text_base_reg    <= cfg_wdata;
                CFG_TEXT_SIZE:    text_size_reg    <= cfg_wdata;
                CFG_SYMBOL_COUNT: symbol_count_reg <= cfg_wdata[SCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: capture the transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    // Stage 2: classify and decode the target.
    ard_decode u_decode (
        .reloc_type    (in_data_reg[7:0]),
        .place_address (in_data_reg[39:8]),
        .insn_word     (in_data_reg[71:40]),
        .symbol_index  (in_data_reg[87:72]),
        .symbol_value  (in_data_reg[119:88]),
        .text_base     (text_base_reg),
        .text_size     (text_size_reg),
        .symbol_count  (symbol_count_reg),
        .dec           (dec_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
        end else if (advance) begin
            dec_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            dec_reg <= dec_next;
        end
    end

    // Stage 3: addend and 16-bit signed range flag. The decode stage zeroed both
    // operands for non-applied entries, so those come out as zero here.
    always_comb begin
        addend        = dec_reg.target - dec_reg.sym_masked;
        short_addend  = (addend[WORD_W-1:15] == '0) || (addend[WORD_W-1:15] == '1);
        if (dec_reg.status != ST_APPLIED) begin
            short_addend = 1'b0;
        end
        out_data_next = {4'b0000, short_addend, addend, dec_reg.target,
                         dec_reg.final_type, dec_reg.status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= dec_valid_reg;
        end
    end

    // Hold the result while the downstream side stalls.
    always_ff @(posedge aclk) begin
        if (advance && dec_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: sv/ard_decode.sv
// Combinational decode of one relocation entry: classification and target.
// Depends on ard_pkg.
`timescale 1ns / 1ps

module ard_decode
    import ard_pkg::*;
(
    input  logic [TYPE_W-1:0] reloc_type,
    input  logic [ADDR_W-1:0] place_address,
    input  logic [WORD_W-1:0] insn_word,
    input  logic [SIDX_W-1:0] symbol_index,
    input  logic [WORD_W-1:0] symbol_value,
    input  logic [ADDR_W-1:0] text_base,
    input  logic [ADDR_W-1:0] text_size,
    input  logic [SCNT_W-1:0] symbol_count,
    output dec_t              dec
);

    logic [TYPE_W-1:0] ftype;
    logic [ADDR_W-1:0] offset;
    logic              outside;
    logic              ignored;
    logic              applied_type;
    logic              bad_sym;
    logic              pc_rel;
    logic [WORD_W-1:0] base_val;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] thm_off;
    logic [15:0]       arm_imm16;
    logic [15:0]       thm_imm16;
    logic              s_bit;
    logic [15:0]       hw_hi;
    logic [15:0]       hw_lo;
    status_t           status;

    always_comb begin
        ftype   = (reloc_type == T_THM_JUMP24) ? T_THM_CALL : reloc_type;
        offset  = place_address - text_base;
        outside = (offset >= text_size);
        ignored = (ftype == T_NONE) || (ftype == T_V4BX) || (ftype == T_THM_PC11);
        bad_sym = ({1'b0, symbol_index} >= symbol_count);
    end

    // Thumb halfwords: first halfword sits in the low bits of the word
    always_comb begin
        hw_hi   = insn_word[15:0];
        hw_lo   = insn_word[31:16];
        s_bit   = hw_hi[10];
        thm_off = {{7{s_bit}}, s_bit, ~(hw_lo[13] ^ s_bit), ~(hw_lo[11] ^ s_bit),
                   hw_hi[9:0], hw_lo[10:0], 1'b0};
        arm_imm16 = {insn_word[19:16], insn_word[11:0]};
        thm_imm16 = {insn_word[3:0], insn_word[10], insn_word[30:28], insn_word[23:16]};
    end

    always_comb begin
        applied_type = 1'b1;
        pc_rel       = 1'b0;
        base_val     = '0;
        mask         = MASK_FULL;
        unique case (ftype) inside
            T_ABS32, T_TARGET1: begin
                base_val = insn_word;
            end
            T_REL32, T_TARGET2: begin
                base_val = insn_word;
                pc_rel   = 1'b1;
            end
            T_PREL31: begin
                base_val = {insn_word[30], insn_word[30:0]};
                pc_rel   = 1'b1;
            end
            T_THM_CALL: begin
                base_val = thm_off;
                pc_rel   = 1'b1;
                mask     = MASK_THM_CALL;
            end
            T_CALL, T_JUMP24: begin
                base_val = {{6{insn_word[23]}}, insn_word[23:0], 2'b00};
                pc_rel   = 1'b1;
            end
            T_MOVW: begin
                base_val = {16'h0000, arm_imm16};
                mask     = MASK_MOVW;
            end
            T_MOVT: begin
                base_val = {arm_imm16, 16'h0000};
                mask     = MASK_MOVT;
            end
            T_THM_MOVW: begin
                base_val = {16'h0000, thm_imm16};
                mask     = MASK_MOVW;
            end
            T_THM_MOVT: begin
                base_val = {thm_imm16, 16'h0000};
                mask     = MASK_MOVT;
            end
            default: begin
                applied_type = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (outside) begin
            status = ST_OUTSIDE;
        end else if (ignored) begin
            status = ST_IGNORED;
        end else if (!applied_type) begin
            status = ST_INVALID;
        end else if (bad_sym) begin
            status = ST_BADSYM;
        end else begin
            status = ST_APPLIED;
        end
    end

    // non-applied entries carry zero target and zero symbol, so the addend is zero too
    always_comb begin
        dec.status     = status;
        dec.final_type = ftype;
        if (status == ST_APPLIED) begin
            dec.target     = base_val + (pc_rel ? place_address : '0);
            dec.sym_masked = symbol_value & mask;
        end else begin
            dec.target     = '0;
            dec.sym_masked = '0;
        end
    end

endmodule

FILE: tb/sv/tb_arm_relocation_addend_decoder.sv
// Self-checking testbench for arm_relocation_addend_decoder: random and directed ARM REL
// entries are streamed in, every result is predicted in the bench and checked field by field.
// Depends on ard_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_arm_relocation_addend_decoder;
    import ard_pkg::*;

    // Stop when this many cycles pass without a transfer on either side.
    localparam int STALL_LIMIT  = 2000;
    // Cycles to let the three-stage pipeline settle after the last result.
    localparam int PIPE_SETTLE  = 8;
    // Index 3 is not a register; a write there must leave the window alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One REL entry, laid out exactly as s_tdata (reloc_type in the low byte).
    typedef struct packed {
        logic [WORD_W-1:0] sym_value;
        logic [SIDX_W-1:0] sym_index;
        logic [WORD_W-1:0] insn;
        logic [ADDR_W-1:0] place;
        logic [TYPE_W-1:0] rtype;
    } reloc_entry_t;

    // One decode result, laid out exactly as m_tdata (status in the low bits).
    typedef struct packed {
        logic [3:0]        pad;
        logic              short_addend;
        logic [WORD_W-1:0] addend;
        logic [WORD_W-1:0] target;
        logic [TYPE_W-1:0] final_type;
        status_t           status;
    } reloc_decode_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Bench copy of the configuration registers.
    logic [ADDR_W-1:0]    text_base_q    = '0;
    logic [WORD_W-1:0]    text_size_q    = '0;
    logic [SCNT_W-1:0]    symbol_count_q = '0;

    reloc_entry_t  reloc_backlog[$];     // entries waiting for the driver
    reloc_decode_t expected_decodes[$];  // predicted results, oldest first
    reloc_entry_t  entry_on_bus;         // entry currently held on s_tdata

    int sender_idle_pct   = 10;
    int receiver_idle_pct = 64;
    int mismatch_count    = 0;
    int stall_cycles      = 0;

    arm_relocation_addend_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: classify the entry against the current window, decode the
    // target from the instruction word and form the addend.
    // ------------------------------------------------------------------
    function automatic reloc_decode_t decode_reloc(input reloc_entry_t e);
        reloc_decode_t     r;
        logic [TYPE_W-1:0] ty;
        logic [WORD_W-1:0] offset_in_text;
        logic [WORD_W-1:0] sym_mask;
        logic [WORD_W-1:0] biased;
        logic              s;
        logic              i1;
        logic              i2;
        r  = '0;
        ty = (e.rtype == T_THM_JUMP24) ? T_THM_CALL : e.rtype;
        r.final_type   = ty;
        offset_in_text = e.place - text_base_q;   // wraps modulo 2^32

        if (offset_in_text >= text_size_q) begin
            r.status = ST_OUTSIDE;
            return r;
        end
        case (ty)
            T_NONE, T_V4BX, T_THM_PC11: begin
                r.status = ST_IGNORED;
                return r;
            end
            T_ABS32, T_TARGET1, T_REL32, T_TARGET2, T_PREL31, T_THM_CALL, T_CALL,
            T_JUMP24, T_MOVW, T_MOVT, T_THM_MOVW, T_THM_MOVT: ;
            default: begin
                r.status = ST_INVALID;
                return r;
            end
        endcase
        if (32'(e.sym_index) >= 32'(symbol_count_q)) begin
            r.status = ST_BADSYM;
            return r;
        end

        r.status = ST_APPLIED;
        sym_mask = MASK_FULL;
        case (ty)
            T_ABS32, T_TARGET1: r.target = e.insn;
            T_REL32, T_TARGET2: r.target = e.insn + e.place;
            // 31-bit signed offset
            T_PREL31: r.target = {e.insn[30], e.insn[30:0]} + e.place;
            // Thumb BL: first halfword in the low bits holds S and imm10,
            // second halfword holds J1, J2 and imm11
            T_THM_CALL: begin
                s  = e.insn[10];
                i1 = ~(e.insn[29] ^ s);
                i2 = ~(e.insn[27] ^ s);
                r.target = e.place + {{7{s}}, s, i1, i2, e.insn[9:0], e.insn[26:16], 1'b0};
                sym_mask = MASK_THM_CALL;
            end
            T_CALL, T_JUMP24:
                r.target = {{6{e.insn[23]}}, e.insn[23:0], 2'b00} + e.place;
            T_MOVW: begin
                r.target = {16'h0000, e.insn[19:16], e.insn[11:0]};
                sym_mask = MASK_MOVW;
            end
            T_MOVT: begin
                r.target = {e.insn[19:16], e.insn[11:0], 16'h0000};
                sym_mask = MASK_MOVT;
            end
            T_THM_MOVW: begin
                r.target = {16'h0000, e.insn[3:0], e.insn[10], e.insn[30:28], e.insn[23:16]};
                sym_mask = MASK_MOVW;
            end
            default: begin    // Thumb MOVT, the only applied type left
                r.target = {e.insn[3:0], e.insn[10], e.insn[30:28], e.insn[23:16], 16'h0000};
                sym_mask = MASK_MOVT;
            end
        endcase
        r.addend       = r.target - (e.sym_value & sym_mask);
        biased         = r.addend + 32'h0000_8000;
        r.short_addend = (biased < 32'h0001_0000);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [TYPE_W-1:0] applied_type(input int unsigned k);
        case (k)
            0:       return T_ABS32;
            1:       return T_TARGET1;
            2:       return T_REL32;
            3:       return T_TARGET2;
            4:       return T_PREL31;
            5:       return T_THM_CALL;
            6:       return T_CALL;
            7:       return T_JUMP24;
            8:       return T_MOVW;
            9:       return T_MOVT;
            10:      return T_THM_MOVW;
            default: return T_THM_MOVT;
        endcase
    endfunction

    // Mostly well-formed entries inside the window with a loaded symbol;
    // the rest hit the ignored, invalid, outside and bad-symbol paths.
    function automatic reloc_entry_t random_entry();
        reloc_entry_t  e;
        reloc_decode_t trial;
        int unsigned   roll;
        roll = $urandom_range(99);
        if (roll < 70)
            e.rtype = applied_type($urandom_range(11));
        else if (roll < 78)
            case ($urandom_range(2))
                0:       e.rtype = T_NONE;
                1:       e.rtype = T_V4BX;
                default: e.rtype = T_THM_PC11;
            endcase
        else if (roll < 83)
            e.rtype = T_THM_JUMP24;
        else
            e.rtype = TYPE_W'($urandom_range(255));

        if (text_size_q != 0 && $urandom_range(99) < 85)
            e.place = text_base_q + ($urandom % text_size_q);
        else
            e.place = $urandom;

        if (symbol_count_q != 0 && $urandom_range(99) < 85)
            e.sym_index = SIDX_W'($urandom % 32'(symbol_count_q));
        else
            e.sym_index = SIDX_W'($urandom_range(65535));

        e.insn      = $urandom;
        e.sym_value = $urandom;
        // Pull the symbol close to the target so short addends show up too.
        if ($urandom_range(99) < 35) begin
            trial = decode_reloc(e);
            if (trial.status == ST_APPLIED)
                e.sym_value = trial.target - $urandom_range(80000) + 32'd40000;
        end
        return e;
    endfunction

    task automatic queue_entry(input logic [TYPE_W-1:0] rtype, input logic [ADDR_W-1:0] place,
                               input logic [WORD_W-1:0] insn, input logic [SIDX_W-1:0] idx,
                               input logic [WORD_W-1:0] value);
        reloc_entry_t e;
        e.rtype     = rtype;
        e.place     = place;
        e.insn      = insn;
        e.sym_index = idx;
        e.sym_value = value;
        reloc_backlog.push_back(e);
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
            reloc_backlog.push_back(random_entry());
    endtask

    // Hold until every entry has been sent and every result has come back,
    // then let the pipeline settle. Sample on the falling edge so the driver
    // and monitor updates of the last rising edge are all visible.
    task automatic wait_drained();
        @(negedge aclk);
        while (reloc_backlog.size() != 0 || s_tvalid || expected_decodes.size() != 0)
            @(negedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // Called right after a rising edge; the write lands on the next one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic set_window(input logic [ADDR_W-1:0] base, input logic [WORD_W-1:0] size,
                              input logic [SCNT_W-1:0] count);
        write_reg(CFG_TEXT_BASE, base);
        write_reg(CFG_TEXT_SIZE, size);
        write_reg(CFG_SYMBOL_COUNT, WORD_W'(count));
        cfg_we         <= 1'b0;
        text_base_q    = base;
        text_size_q    = size;
        symbol_count_q = count;
    endtask

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        $display("%0t ns: mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_decode(input logic [M_TDATA_W-1:0] beat);
        reloc_decode_t got;
        reloc_decode_t want;
        got = beat;
        if (expected_decodes.size() == 0) begin
            flag_mismatch("unexpected result transfer", beat[31:0], '0);
            return;
        end
        want = expected_decodes.pop_front();
        if (got.status != want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.final_type != want.final_type)
            flag_mismatch("final_type", 32'(got.final_type), 32'(want.final_type));
        if (got.target != want.target)
            flag_mismatch("target_value", got.target, want.target);
        if (got.addend != want.addend)
            flag_mismatch("addend_value", got.addend, want.addend);
        if (got.short_addend != want.short_addend)
            flag_mismatch("short_addend", 32'(got.short_addend), 32'(want.short_addend));
    endtask

    // ------------------------------------------------------------------
    // Driver: predict on each accepted transfer, then load the next entry
    // whenever the slot is free and the sender is not idling this cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_decodes.push_back(decode_reloc(entry_on_bus));
            if (!s_tvalid || s_tready) begin
                if (reloc_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    entry_on_bus = reloc_backlog.pop_front();
                    s_tdata  <= entry_on_bus;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result, stall the receiver at random.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_decode(m_tdata);
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: end the run if neither side moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Out of reset the section is empty, so every entry lands outside.
        queue_entry(T_ABS32, 32'h0000_0000, 32'h0000_1234, 16'd0, 32'h0000_0000);
        queue_entry(T_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        wait_drained();

        // Directed pass: section 0x8000..0x17FFF, 100 symbols.
        set_window(32'h0000_8000, 32'h0001_0000, 17'd100);
        queue_entry(T_ABS32, 32'h0000_8000, 32'hFFFF_FFFF, 16'd0, 32'h0000_0000);
        queue_entry(T_TARGET1, 32'h0000_9000, 32'h1234_5678, 16'd99, 32'h1234_5600);
        queue_entry(T_REL32, 32'h0001_7FFF, 32'h0000_0100, 16'd5, 32'h0001_7F00);
        queue_entry(T_TARGET2, 32'h0000_A000, 32'h8000_0000, 16'd1, 32'hFFFF_FFFF);
        queue_entry(T_PREL31, 32'h0000_A004, 32'h4000_0000, 16'd2, 32'h0000_0000);
        queue_entry(T_PREL31, 32'h0000_A008, 32'hBFFF_FFFF, 16'd2, 32'h4000_A000);
        // Thumb BL with S set, then with S clear
        queue_entry(T_THM_CALL, 32'h0000_B000, 32'hFFFE_F7FF, 16'd3, 32'h0000_AFFF);
        queue_entry(T_THM_CALL, 32'h0000_B004, 32'hD800_F000, 16'd3, 32'hFFFF_FFFF);
        // THM_JUMP24 comes out renamed to THM_CALL
        queue_entry(T_THM_JUMP24, 32'h0000_B008, 32'hB800_F000, 16'd4, 32'h0000_B00B);
        queue_entry(T_CALL, 32'h0000_C000, 32'hEB80_0000, 16'd6, 32'h0000_0000);
        queue_entry(T_JUMP24, 32'h0000_C004, 32'hEA7F_FFFF, 16'd7, 32'h0200_C000);
        queue_entry(T_MOVW, 32'h0000_D000, 32'hE30F_0FFF, 16'd8, 32'hFFFF_FFFF);
        queue_entry(T_MOVT, 32'h0000_D004, 32'hE34F_0FFF, 16'd8, 32'hFFFF_FFFF);
        queue_entry(T_THM_MOVW, 32'h0000_D008, 32'h7F5A_F64A, 16'd9, 32'h0000_0000);
        queue_entry(T_THM_MOVT, 32'h0000_D00C, 32'hFFFF_F6CF, 16'd9, 32'h1234_5678);
        queue_entry(T_NONE, 32'h0000_E000, 32'h0000_0000, 16'd0, 32'h0000_0000);
        queue_entry(T_V4BX, 32'h0000_E004, 32'hE12F_FF1E, 16'd0, 32'h0000_0000);
        queue_entry(T_THM_PC11, 32'h0000_E008, 32'h0000_E7FE, 16'd0, 32'h0000_0000);
        queue_entry(8'd1, 32'h0000_E00C, 32'h1111_1111, 16'd0, 32'h0000_0000);
        queue_entry(8'd255, 32'h0000_E010, 32'h2222_2222, 16'd0, 32'h0000_0000);
        // symbol index at and far beyond the loaded count
        queue_entry(T_ABS32, 32'h0000_E014, 32'h3333_3333, 16'd100, 32'h0000_0000);
        queue_entry(T_ABS32, 32'h0000_E018, 32'h4444_4444, 16'hFFFF, 32'h0000_0000);
        // just below and just past the section
        queue_entry(T_ABS32, 32'h0000_7FFF, 32'h5555_5555, 16'd0, 32'h0000_0000);
        queue_entry(T_ABS32, 32'h0001_8000, 32'h6666_6666, 16'd0, 32'h0000_0000);
        wait_drained();

        // A write to the unused index must leave the window as it was.
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        queue_entry(T_REL32, 32'h0000_8010, 32'h0000_0010, 16'd50, 32'h0000_8000);
        queue_entry(T_ABS32, 32'h0001_8000, 32'h7777_7777, 16'd0, 32'h0000_0000);
        wait_drained();

        // Random pass 1: sender idles a little, receiver a lot.
        sender_idle_pct   = 10;
        receiver_idle_pct = 64;
        set_window($urandom, 32'h0010_0000, 17'($urandom_range(65536, 1)));
        queue_random(300);
        wait_drained();
        queue_random(300);
        wait_drained();

        // Random pass 2: roles swapped; the section wraps past the top of memory
        // and every symbol index is loaded.
        sender_idle_pct   = 64;
        receiver_idle_pct = 10;
        set_window(32'hFFFF_FF00, 32'h0000_0200, 17'h1_0000);
        queue_random(600);
        wait_drained();

        // Random pass 3: no idling; the whole address space but its top address, a single symbol.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_window(32'h0000_0000, 32'hFFFF_FFFF, 17'd1);
        queue_random(500);
        wait_drained();

        // No symbols loaded: every applied type turns into a bad symbol.
        set_window($urandom, 32'hFFFF_FFFF, 17'd0);
        queue_random(100);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/ard_pkg.sv
sv/ard_decode.sv
sv/arm_relocation_addend_decoder.sv
tb/sv/tb_arm_relocation_addend_decoder.sv
